[src/hpom_pkg.sv]
// Shared types, constants and the quarter-wave sine table for the heading PID omni mixer.
`timescale 1ns / 1ps
package hpom_pkg;

  // Field widths
  localparam int TRAVEL_BITS = 10;
  localparam int SPEED_BITS  = 10;
  localparam int HEAD_BITS   = 14;
  localparam int GAIN_BITS   = 16;
  localparam int LEVEL_BITS  = 8;
  localparam int WHEELS      = 4;
  localparam int WHEEL_BITS  = $clog2(WHEELS);

  // Stream framing
  localparam int IN_FIELD_BITS  = TRAVEL_BITS + SPEED_BITS + HEAD_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = WHEELS * (LEVEL_BITS + 1);
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Config port
  localparam int CFG_IDX_BITS = 2;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_KP = 2'd0,
    REG_KI = 2'd1,
    REG_KD = 2'd2
  } reg_idx_e;
  localparam logic signed [GAIN_BITS-1:0] KP_RESET = 16'sd256;

  // Controller arithmetic
  localparam int SUM_BITS   = 32;
  localparam int ERR_BITS   = HEAD_BITS;
  localparam int DIFF_BITS  = ERR_BITS + 1;
  localparam int MUL_B_BITS = SUM_BITS + 1;
  localparam int PROD_BITS  = GAIN_BITS + MUL_B_BITS;
  localparam int ACC_BITS   = GAIN_BITS + SUM_BITS;
  localparam int FRAC_BITS  = 8;
  localparam int Q_BITS     = ACC_BITS - FRAC_BITS;

  localparam logic signed [ERR_BITS-1:0] ERR_MIN = {1'b1, {(ERR_BITS-1){1'b0}}};
  localparam logic signed [ERR_BITS-1:0] ERR_MAX = {1'b0, {(ERR_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};

  // Angles: full circle in 1/16 degree
  localparam int CIRCLE16   = 5760;
  localparam int ANGLE_BITS = $clog2(CIRCLE16);
  localparam logic [ANGLE_BITS-1:0] CIRCLE_A = ANGLE_BITS'(CIRCLE16);

  // Remainder unit: one digit per cycle, radix 2^DIGIT_BITS
  localparam int DIGIT_BITS = 4;
  localparam int DIGITS     = (Q_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int SH_BITS    = DIGITS * DIGIT_BITS;
  localparam int DCNT_BITS  = $clog2(DIGITS);
  localparam int T_BITS     = ANGLE_BITS + DIGIT_BITS;
  // 2^Q_BITS mod circle, undoes the two's complement offset of a negative quotient
  localparam logic [ANGLE_BITS-1:0] NEG_FIX_A =
    ANGLE_BITS'((longint'(1) << Q_BITS) % CIRCLE16);

  // Sine table
  localparam int SINE_STEPS  = 1440;
  localparam int HALF_STEPS  = SINE_STEPS / 2;
  localparam int QTR_STEPS   = SINE_STEPS / 4;
  localparam int IDX_BITS    = $clog2(SINE_STEPS);
  localparam int ADDR_BITS   = $clog2(QTR_STEPS + 1);
  localparam int ANGLE_SHIFT = $clog2(CIRCLE16 / SINE_STEPS);
  localparam int MAG_BITS    = 15;
  localparam int DRIVE_SHIFT = 14;
  localparam int DPROD_BITS  = MAG_BITS + SPEED_BITS;
  localparam int WSUM_BITS   = ANGLE_BITS + 2;

  localparam longint HALFPI_Q30   = 64'sd1686629713;
  localparam int     TAYLOR_TERMS = 6;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156};

  // Wheel mounting offsets in 1/16 degree: A, B, C, D
  typedef logic [ANGLE_BITS-1:0] woff_t [WHEELS];
  localparam woff_t WHEEL_OFF16 = '{
    ANGLE_BITS'(135 * 16), ANGLE_BITS'(45 * 16),
    ANGLE_BITS'(315 * 16), ANGLE_BITS'(225 * 16)
  };

  typedef logic [MAG_BITS-1:0] qtab_t [QTR_STEPS + 1];

  // sin((pi/2)*m/SINE_STEPS) in Q14, Taylor series in Q30
  function automatic logic [MAG_BITS-1:0] quarter_sine(input int m);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          s;
    x    = longint'((longint'(m) * HALFPI_Q30 + longint'(SINE_STEPS / 2)) / SINE_STEPS);
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[n-1];
      if (n[0]) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    return MAG_BITS'((s + 32768) >>> 16);
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int j = 0; j <= QTR_STEPS; j++) begin
      t[j] = quarter_sine(4 * j);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // Queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int FCNT_BITS  = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [ANGLE_BITS-1:0]         pid_angle;
    logic signed [TRAVEL_BITS-1:0] travel;
    logic [SPEED_BITS-1:0]         speed;
  } job_t;

  typedef struct packed {
    logic                  reverse;
    logic [LEVEL_BITS-1:0] level;
  } wheel_t;

  typedef wheel_t [WHEELS-1:0] wheels_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL_P,
    F_MUL_I,
    F_MUL_D,
    F_ACC,
    F_MOD,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ISSUE,
    B_DRAIN,
    B_LOAD
  } back_state_e;

endpackage

[src/hpom_fifo.sv]
// Two-entry job queue between the PID front end and the wheel back end.
`timescale 1ns / 1ps
module hpom_fifo
  import hpom_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_data_o
);

  job_t                 mem_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FCNT_BITS-1:0] count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = count_q < FCNT_BITS'(FIFO_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/hpom_front.sv]
// Front end: takes an item, updates the PID state and reduces the correction angle.
`timescale 1ns / 1ps
module hpom_front
  import hpom_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [GAIN_BITS-1:0]          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [TRAVEL_BITS-1:0] travel_i,
  input  logic [SPEED_BITS-1:0]         speed_i,
  input  logic signed [HEAD_BITS-1:0]   heading_i,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output job_t                          job_o
);

  front_state_e state_q, state_d;

  logic signed [GAIN_BITS-1:0]   kp_q, ki_q, kd_q;
  logic signed [SUM_BITS-1:0]    total_q;
  logic signed [ERR_BITS-1:0]    last_q;
  logic signed [ERR_BITS-1:0]    err_q;
  logic signed [DIFF_BITS-1:0]   diff_q;
  logic signed [TRAVEL_BITS-1:0] travel_q;
  logic [SPEED_BITS-1:0]         speed_q;
  logic signed [PROD_BITS-1:0]   prod_q;
  logic signed [ACC_BITS-1:0]    acc_q;
  logic [SH_BITS-1:0]            sh_q;
  logic [ANGLE_BITS-1:0]         rem_q;
  logic [DCNT_BITS-1:0]          cnt_q;
  logic                          neg_q;

  logic                          accept;
  logic signed [ERR_BITS-1:0]    err_c;
  logic signed [SUM_BITS:0]      sum_ext;
  logic signed [SUM_BITS-1:0]    total_c;
  logic signed [DIFF_BITS-1:0]   diff_c;
  logic signed [SUM_BITS-1:0]    negsum_c;
  logic signed [GAIN_BITS-1:0]   mul_a;
  logic signed [MUL_B_BITS-1:0]  mul_b;
  logic signed [PROD_BITS-1:0]   prod_c;
  logic signed [ACC_BITS-1:0]    acc_next;
  logic [T_BITS-1:0]             t_c;
  logic [ANGLE_BITS-1:0]         rem_c;
  logic [ANGLE_BITS-1:0]         fix_c;

  assign accept = in_valid_i && in_ready_o;

  // error = -heading, the one unrepresentable case pinned to the max
  assign err_c   = (heading_i == ERR_MIN) ? ERR_MAX : -heading_i;
  assign sum_ext = {total_q[SUM_BITS-1], total_q}
                 + {{(SUM_BITS + 1 - ERR_BITS){err_c[ERR_BITS-1]}}, err_c};
  assign total_c = (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1])
                 ? (sum_ext[SUM_BITS] ? SUM_MIN : SUM_MAX)
                 : sum_ext[SUM_BITS-1:0];
  assign diff_c  = {last_q[ERR_BITS-1], last_q} - {err_c[ERR_BITS-1], err_c};
  assign negsum_c = (total_q == SUM_MIN) ? SUM_MAX : -total_q;

  // shared multiplier operand select
  always_comb begin
    mul_a = kp_q;
    mul_b = {{(MUL_B_BITS - ERR_BITS){err_q[ERR_BITS-1]}}, err_q};
    case (state_q)
      F_MUL_I: begin
        mul_a = ki_q;
        mul_b = {negsum_c[SUM_BITS-1], negsum_c};
      end
      F_MUL_D: begin
        mul_a = kd_q;
        mul_b = {{(MUL_B_BITS - DIFF_BITS){diff_q[DIFF_BITS-1]}}, diff_q};
      end
      default: ;
    endcase
  end

  assign prod_c   = mul_a * mul_b;
  assign acc_next = acc_q + prod_q[ACC_BITS-1:0];

  // one radix-16 digit of the remainder by the circle
  always_comb begin
    t_c   = {rem_q, sh_q[SH_BITS-1 -: DIGIT_BITS]};
    rem_c = t_c[ANGLE_BITS-1:0];
    for (int i = 1; i < (1 << DIGIT_BITS); i++) begin
      if (t_c >= T_BITS'(i * CIRCLE16)) begin
        rem_c = ANGLE_BITS'(t_c - T_BITS'(i * CIRCLE16));
      end
    end
  end

  // remove the 2^Q_BITS offset for a negative quotient
  always_comb begin
    if (!neg_q) begin
      fix_c = rem_q;
    end else if (rem_q >= NEG_FIX_A) begin
      fix_c = rem_q - NEG_FIX_A;
    end else begin
      fix_c = rem_q + (CIRCLE_A - NEG_FIX_A);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (in_valid_i) state_d = F_MUL_P;
      F_MUL_P: state_d = F_MUL_I;
      F_MUL_I: state_d = F_MUL_D;
      F_MUL_D: state_d = F_ACC;
      F_ACC:   state_d = F_MOD;
      F_MOD:   if (cnt_q == DCNT_BITS'(DIGITS - 1)) state_d = F_PUSH;
      F_PUSH:  if (job_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    job_valid_o = 1'b0;
    unique case (state_q)
      F_IDLE:  in_ready_o  = 1'b1;
      F_PUSH:  job_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign job_o.pid_angle = fix_c;
  assign job_o.travel    = travel_q;
  assign job_o.speed     = speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      kp_q    <= KP_RESET;
      ki_q    <= '0;
      kd_q    <= '0;
      total_q <= '0;
      last_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_KP:  kp_q <= cfg_data_i;
          REG_KI:  ki_q <= cfg_data_i;
          REG_KD:  kd_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        total_q <= total_c;
        last_q  <= err_c;
      end
      if (state_q == F_ACC) begin
        cnt_q <= '0;
      end else if (state_q == F_MOD) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q    <= err_c;
      diff_q   <= diff_c;
      travel_q <= travel_i;
      speed_q  <= speed_i;
    end
    case (state_q)
      F_MUL_P: prod_q <= prod_c;
      F_MUL_I: begin
        acc_q  <= prod_q[ACC_BITS-1:0];
        prod_q <= prod_c;
      end
      F_MUL_D: begin
        acc_q  <= acc_next;
        prod_q <= prod_c;
      end
      F_ACC: begin
        // floor to 1/16 degree, then reduce the quotient digit by digit
        sh_q  <= SH_BITS'(acc_next[ACC_BITS-1:FRAC_BITS]);
        neg_q <= acc_next[ACC_BITS-1];
        rem_q <= '0;
      end
      F_MOD: begin
        sh_q  <= sh_q << DIGIT_BITS;
        rem_q <= rem_c;
      end
      default: ;
    endcase
  end

endmodule

[src/hpom_back.sv]
// Back end: per-wheel angle, sine lookup, speed scaling and clamping, plus the output register.
`timescale 1ns / 1ps
module hpom_back
  import hpom_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    job_valid_i,
  output logic    job_ready_o,
  input  job_t    job_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output wheels_t out_data_o
);

  back_state_e state_q, state_d;

  job_t                  job_q;
  logic [WHEEL_BITS-1:0] wcnt_q;
  wheels_t               res_q;
  logic                  out_valid_q;
  wheels_t               out_q;

  // wheel pipeline
  logic                  v1_q, v2_q, v3_q, v4_q;
  logic [WHEEL_BITS-1:0] w1_q, w2_q, w3_q, w4_q;
  logic [ANGLE_BITS-1:0] ang1_q;
  logic [ADDR_BITS-1:0]  addr2_q;
  logic                  neg2_q, neg3_q, neg4_q;
  logic [MAG_BITS-1:0]   mag3_q;
  logic [DPROD_BITS-1:0] prod4_q;

  logic                          issue, load;
  logic signed [TRAVEL_BITS+4:0] tscaled;
  logic [WSUM_BITS-1:0]          wsum;
  logic [ANGLE_BITS-1:0]         ang_c;
  logic [IDX_BITS-1:0]           idx_c;
  logic [IDX_BITS-1:0]           half_c;
  logic                          neg_c;
  logic [ADDR_BITS-1:0]          addr_c;
  logic [DPROD_BITS-DRIVE_SHIFT-1:0] drive_c;
  wheel_t                        wres_c;

  // travel*16 biased by two full circles keeps every wheel sum non-negative,
  // across the whole 10-bit travel range
  assign tscaled = {job_q.travel[TRAVEL_BITS-1], job_q.travel, 4'b0}
                 + (TRAVEL_BITS + 5)'(2 * CIRCLE16);
  assign wsum    = WSUM_BITS'(job_q.pid_angle)
                 + WSUM_BITS'(unsigned'(tscaled))
                 + WSUM_BITS'(WHEEL_OFF16[wcnt_q]);

  // wheel sum stays below six circles
  always_comb begin
    if (wsum >= WSUM_BITS'(5 * CIRCLE16)) begin
      ang_c = ANGLE_BITS'(wsum - WSUM_BITS'(5 * CIRCLE16));
    end else if (wsum >= WSUM_BITS'(4 * CIRCLE16)) begin
      ang_c = ANGLE_BITS'(wsum - WSUM_BITS'(4 * CIRCLE16));
    end else if (wsum >= WSUM_BITS'(3 * CIRCLE16)) begin
      ang_c = ANGLE_BITS'(wsum - WSUM_BITS'(3 * CIRCLE16));
    end else if (wsum >= WSUM_BITS'(2 * CIRCLE16)) begin
      ang_c = ANGLE_BITS'(wsum - WSUM_BITS'(2 * CIRCLE16));
    end else if (wsum >= WSUM_BITS'(CIRCLE16)) begin
      ang_c = ANGLE_BITS'(wsum - WSUM_BITS'(CIRCLE16));
    end else begin
      ang_c = ANGLE_BITS'(wsum);
    end
  end

  // quarter-wave fold of the sine index
  assign idx_c  = ang1_q[ANGLE_BITS-1:ANGLE_SHIFT];
  assign neg_c  = idx_c >= IDX_BITS'(HALF_STEPS);
  assign half_c = neg_c ? idx_c - IDX_BITS'(HALF_STEPS) : idx_c;
  assign addr_c = (half_c > IDX_BITS'(QTR_STEPS))
                ? ADDR_BITS'(IDX_BITS'(HALF_STEPS) - half_c)
                : ADDR_BITS'(half_c);

  // truncate toward zero on the magnitude, clamp, reverse only for nonzero drive
  assign drive_c       = prod4_q[DPROD_BITS-1:DRIVE_SHIFT];
  assign wres_c.level  = (drive_c > (DPROD_BITS-DRIVE_SHIFT)'({LEVEL_BITS{1'b1}}))
                       ? {LEVEL_BITS{1'b1}} : drive_c[LEVEL_BITS-1:0];
  assign wres_c.reverse = neg4_q && (wres_c.level != '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (job_valid_i) state_d = B_ISSUE;
      B_ISSUE: if (wcnt_q == WHEEL_BITS'(WHEELS - 1)) state_d = B_DRAIN;
      B_DRAIN: if (!(v1_q || v2_q || v3_q || v4_q)) state_d = B_LOAD;
      B_LOAD:  if (!out_valid_q || out_ready_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = 1'b0;
    issue       = 1'b0;
    load        = 1'b0;
    unique case (state_q)
      B_IDLE:  job_ready_o = 1'b1;
      B_ISSUE: issue       = 1'b1;
      B_LOAD:  load        = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      wcnt_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (job_valid_i && job_ready_o) begin
        wcnt_q <= '0;
      end else if (issue) begin
        wcnt_q <= wcnt_q + 1'b1;
      end
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      job_q <= job_i;
    end
    w1_q    <= wcnt_q;
    ang1_q  <= ang_c;
    w2_q    <= w1_q;
    addr2_q <= addr_c;
    neg2_q  <= neg_c;
    w3_q    <= w2_q;
    mag3_q  <= QTAB[addr2_q];
    neg3_q  <= neg2_q;
    w4_q    <= w3_q;
    prod4_q <= DPROD_BITS'(mag3_q) * DPROD_BITS'(job_q.speed);
    neg4_q  <= neg3_q;
    if (v4_q) begin
      res_q[w4_q] <= wres_c;
    end
    if (load) begin
      out_q <= res_q;
    end
  end

endmodule

[src/heading_pid_omni_wheel_mixer_top.sv]
// Top level of the heading-hold PID and four-wheel omni drive mixer.
`timescale 1ns / 1ps
// The front end takes no new item until the last one is in the queue: accept, then
//   F_MUL_P, F_MUL_I, F_MUL_D and F_ACC on the shared 16x33 multiplier and accumulator,
//   10 radix-16 remainder steps, then the queue push.
// The back end takes one item at a time (4 wheels issued into a 4-stage pipeline, drain, load).
// Reset (rst_ni, async, active low): kp=1.0, ki=kd=0, error sum and last error cleared,
//   queue and output register empty. No clearing pass; items are taken right after reset.
module heading_pid_omni_wheel_mixer_top
  import hpom_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [9:0] travel_angle, [19:10] speed_limit, [33:20] heading, rest zero
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [7:0] wheel_a_level, [8] wheel_a_reverse, [16:9] wheel_b_level, [17] wheel_b_reverse,
  // [25:18] wheel_c_level, [26] wheel_c_reverse, [34:27] wheel_d_level,
  // [35] wheel_d_reverse, rest zero
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  // gain writes: index 0 kp, 1 ki, 2 kd (signed Q8.8); other indexes are dropped
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [GAIN_BITS-1:0]      cfg_data_i
);

  logic    job_in_valid, job_in_ready;
  job_t    job_in;
  logic    job_out_valid, job_out_ready;
  job_t    job_out;
  wheels_t wheels;

  // gains are plain registers, so a write is always accepted
  assign cfg_ready_o = 1'b1;

  // front: PID update and reduction of the correction angle to one circle
  hpom_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .travel_i    (s_axis_tdata[TRAVEL_BITS-1:0]),
    .speed_i     (s_axis_tdata[TRAVEL_BITS +: SPEED_BITS]),
    .heading_i   (s_axis_tdata[TRAVEL_BITS + SPEED_BITS +: HEAD_BITS]),
    .job_valid_o (job_in_valid),
    .job_ready_i (job_in_ready),
    .job_o       (job_in)
  );

  // short queue lets the front start the next item while the back is busy
  hpom_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_in_valid),
    .push_ready_o (job_in_ready),
    .push_data_i  (job_in),
    .pop_valid_o  (job_out_valid),
    .pop_ready_i  (job_out_ready),
    .pop_data_o   (job_out)
  );

  // back: four wheels through sine lookup and speed scaling, then the output register
  hpom_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_out_valid),
    .job_ready_o (job_out_ready),
    .job_i       (job_out),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (wheels)
  );

  assign m_axis_tdata = {{(OUT_TDATA_BITS - OUT_FIELD_BITS){1'b0}}, wheels};

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the heading-hold PID omni wheel mixer top level.
`timescale 1ns / 1ps
module tb_top;
  import hpom_pkg::*;

  // Predictor constants, kept apart from the package on purpose
  localparam int     TURN16      = 5760;          // full circle, 1/16 degree
  localparam int     TAB_STEPS   = 1440;          // sine entries per circle
  localparam longint PID_WRAP    = 64'sd1474560;  // 360 degrees in 1/4096 degree
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint SUM_HI      = 64'sd2147483647;
  localparam longint SUM_LO      = -SUM_HI - 1;
  localparam int     MOUNT_DEG [4] = '{135, 45, 315, 225};

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;  // index the block drops
  localparam int LIMIT_CYCLES = 500000;
  localparam int SETTLE_CYCLES = 40;                      // settle time after the last result
  localparam int MAX_PRINTED = 40;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]   cfg_index_i = '0;
  logic [GAIN_BITS-1:0]      cfg_data_i = '0;

  heading_pid_omni_wheel_mixer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow of the controller: gains, integrator and previous error
  longint kp_q8 = 256;
  longint ki_q8 = 0;
  longint kd_q8 = 0;
  longint err_sum = 0;
  longint prev_err = 0;
  int     sine_tab [TAB_STEPS];

  wheels_t wheel_drive_q [$];   // expected drives, oldest first
  int      items_sent = 0;
  int      results_seen = 0;
  int      mismatches = 0;
  int      gain_sets = 0;
  int      cycle_count = 0;
  bit      idle_on = 1'b1;       // random gaps and stalls enabled
  int      stall_left = 0;
  int      stall_draw;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // sin((pi/2)*m/TAB_STEPS) in Q14 via Taylor series in Q30
  function automatic int quarter_q14(input longint m);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x    = longint'((m * HALF_PI_Q30 + longint'(TAB_STEPS / 2)) / TAB_STEPS);
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x2) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return int'((acc + 32768) >>> 16);
  endfunction

  function automatic void build_sine_tab();
    longint m;
    bit     neg;
    for (int k = 0; k < TAB_STEPS; k++) begin
      m   = 4 * k;
      neg = 1'b0;
      if (m >= 2 * TAB_STEPS) begin
        m   = m - 2 * TAB_STEPS;
        neg = 1'b1;
      end
      if (m > TAB_STEPS) begin
        m = 2 * TAB_STEPS - m;
      end
      sine_tab[k] = neg ? -quarter_q14(m) : quarter_q14(m);
    end
  endfunction

  // Advances the shadow controller by one item and returns the four wheel drives
  function automatic wheels_t mix_wheels(input logic signed [TRAVEL_BITS-1:0] travel,
                                         input logic [SPEED_BITS-1:0] speed,
                                         input logic signed [HEAD_BITS-1:0] heading);
    wheels_t w;
    longint  err;
    longint  neg_sum;
    longint  pid;
    longint  base;
    longint  ang;
    longint  idx;
    longint  drv;
    err = -longint'(heading);
    if (err > 8191) begin
      err = 8191;   // -(-8192) does not fit the error width
    end
    err_sum = err_sum + err;
    if (err_sum > SUM_HI) begin
      err_sum = SUM_HI;
    end
    if (err_sum < SUM_LO) begin
      err_sum = SUM_LO;
    end
    neg_sum = (err_sum == SUM_LO) ? SUM_HI : -err_sum;
    pid = kp_q8 * err + ki_q8 * neg_sum + kd_q8 * (prev_err - err);
    prev_err = err;
    pid = pid % PID_WRAP;
    if (pid < 0) begin
      pid = pid + PID_WRAP;
    end
    base = pid / 256 + longint'(travel) * 16;
    for (int j = 0; j < 4; j++) begin
      ang = (base + MOUNT_DEG[j] * 16) % TURN16;
      if (ang < 0) begin
        ang = ang + TURN16;
      end
      idx = ang * TAB_STEPS / TURN16;
      if (idx < 0) begin
        idx = 0;
      end
      if (idx >= TAB_STEPS) begin
        idx = TAB_STEPS - 1;
      end
      drv = longint'(sine_tab[idx]) * longint'(speed) / 16384;  // truncates toward zero
      if (drv > 255) begin
        drv = 255;
      end
      if (drv < -255) begin
        drv = -255;
      end
      w[j].reverse = (drv < 0);
      w[j].level   = LEVEL_BITS'((drv < 0) ? -drv : drv);
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
    end
  endtask

  task automatic check_result(input logic [OUT_TDATA_BITS-1:0] data);
    wheels_t got;
    wheels_t want;
    string   name;
    got = data[OUT_FIELD_BITS-1:0];
    if (wheel_drive_q.size() == 0) begin
      report_mismatch("unexpected result, tdata", longint'(data), 0);
    end else begin
      want = wheel_drive_q.pop_front();
      for (int j = 0; j < 4; j++) begin
        name = $sformatf("wheel %c", 8'd97 + j);
        if (got[j].level !== want[j].level) begin
          report_mismatch({name, " level"}, got[j].level, want[j].level);
        end
        if (got[j].reverse !== want[j].reverse) begin
          report_mismatch({name, " reverse"}, got[j].reverse, want[j].reverse);
        end
      end
      if (data[OUT_TDATA_BITS-1:OUT_FIELD_BITS] !== '0) begin
        report_mismatch("tdata padding", data[OUT_TDATA_BITS-1:OUT_FIELD_BITS], 0);
      end
    end
    results_seen++;
  endtask

  // Result side: one transaction, then an optional stall of random length
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        if (stall_left == 1) begin
          m_axis_tready <= 1'b1;
        end
      end else if (!m_axis_tready) begin
        m_axis_tready <= 1'b1;
      end else if (m_axis_tvalid) begin
        check_result(m_axis_tdata);
        stall_draw = idle_on ? $urandom_range(0, 8) : 0;
        if (stall_draw != 0) begin
          m_axis_tready <= 1'b0;
          stall_left    <= stall_draw;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, wheel_drive_q.size());
      $display("[heading_pid_omni_wheel_mixer_top] ERROR");
      $finish;
    end
  end

  // Sends one item and records its prediction on acceptance. tvalid stays high
  // after the transaction so a back-to-back item needs no second update of it.
  task automatic send_item(input logic signed [TRAVEL_BITS-1:0] travel,
                           input logic [SPEED_BITS-1:0] speed,
                           input logic signed [HEAD_BITS-1:0] heading);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= IN_TDATA_BITS'({heading, speed, travel});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    wheel_drive_q.push_back(mix_wheels(travel, speed, heading));
    items_sent++;
  endtask

  // Holds off the sender until every expected result is back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (wheel_drive_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One config transaction; cfg_valid_i is left high for a following write
  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [GAIN_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_KP: kp_q8 = longint'(signed'(data));
      REG_KI: ki_q8 = longint'(signed'(data));
      REG_KD: kd_q8 = longint'(signed'(data));
      default: ;   // dropped by the block
    endcase
  endtask

  task automatic set_gains(input int kp, input int ki, input int kd);
    cfg_write(REG_KP, GAIN_BITS'(kp));
    cfg_write(REG_KI, GAIN_BITS'(ki));
    cfg_write(REG_KD, GAIN_BITS'(kd));
    cfg_valid_i <= 1'b0;
    gain_sets++;
  endtask

  function automatic int draw_gain(input int mode);
    case (mode)
      0: return $urandom_range(0, 1024) - 512;
      1: return $urandom_range(0, 65535) - 32768;
      default: begin
        case ($urandom_range(0, 2))
          0: return -32768;
          1: return 32767;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  // Reset gains (kp 1.0): field extremes, heading at the negative edge, zero drives
  task automatic test_reset_gains();
    idle_on = 1'b1;
    send_item(0, 0, 0);
    send_item(0, 1023, 0);
    send_item(511, 1023, -8192);   // error saturates to 8191
    send_item(-512, 1023, 8191);
    send_item(360, 512, 5760);
    // sender holds here until the block has drained
    wait_idle();
    send_item(-360, 777, -5760);
    send_item(90, 1, 1);           // tiny drives truncate to zero, no reverse
    send_item(-90, 300, -1);
  endtask

  // Dropped register index, then opposite gain extremes with integral and derivative active
  task automatic test_gain_extremes();
    wait_idle();
    cfg_write(REG_UNUSED, 16'h7fff);
    set_gains(-32768, 32767, 32767);
    send_item(0, 1023, 8191);
    send_item(511, 1023, -8192);
    send_item(-512, 640, 100);
    send_item(45, 1023, -100);
    send_item(-1, 1023, 0);
    wait_idle();
    set_gains(32767, -32768, -32768);
    send_item(0, 1023, -8192);
    send_item(511, 1023, 8191);
    send_item(-512, 1023, 0);
    send_item(180, 200, 3000);
    send_item(-180, 1023, -3000);
  endtask

  // Phases of random items, each after the first under freshly drawn gains; two phases run without idling
  task automatic test_random_phases();
    int travel;
    int speed;
    int heading;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      if (phase == 0) begin
        set_gains(256, 0, 0);
      end else begin
        set_gains(draw_gain(phase % 3), draw_gain((phase + 1) % 3), draw_gain(phase % 2));
      end
      idle_on = (phase != 2) && (phase != 4);
      for (int n = 0; n < 170; n++) begin
        travel = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 720) - 360
                                             : $urandom_range(0, 1023) - 512;
        speed = ($urandom_range(0, 9) == 0) ? $urandom_range(1000, 1023)
                                            : $urandom_range(0, 1023);
        case ($urandom_range(0, 9))
          0: heading = ($urandom_range(0, 1) != 0) ? $urandom_range(8100, 8191)
                                                   : -$urandom_range(8100, 8192);
          1: heading = $urandom_range(0, 16383) - 8192;
          default: heading = $urandom_range(0, 11520) - 5760;
        endcase
        send_item(TRAVEL_BITS'(travel), SPEED_BITS'(speed), HEAD_BITS'(heading));
      end
    end
  endtask

  initial begin
    build_sine_tab();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_gains();
    test_gain_extremes();
    test_random_phases();
    wait_idle();
    if (wheel_drive_q.size() != 0) begin
      report_mismatch("results never delivered", 0, wheel_drive_q.size());
    end
    $display("covered %0d items and %0d results under %0d gain settings",
             items_sent, results_seen, gain_sets);
    $display("%0d mismatches in total", mismatches);
    if (mismatches == 0) begin
      $display("[heading_pid_omni_wheel_mixer_top] OK");
    end else begin
      $display("[heading_pid_omni_wheel_mixer_top] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
src/hpom_pkg.sv
src/hpom_fifo.sv
src/hpom_front.sv
src/hpom_back.sv
src/heading_pid_omni_wheel_mixer_top.sv
tb/sv/tb_top.sv
